### hdl/amgs_pkg.sv
// Shared types and constants for the adjacency matrix graph store.
// Used by the controller, the datapath and the top level; depends on nothing.
package amgs_pkg;

  // Width of the id ports and of the command port.
  localparam int IdPortW = 32;
  localparam int CmdW    = 3;

  // Command codes. Codes 5 to 7 carry no meaning and are answered with an error.
  typedef enum logic [CmdW-1:0] {
    CMD_ADD_VERTEX  = 3'd0,
    CMD_ADD_EDGE    = 3'd1,
    CMD_EDGE_EXISTS = 3'd2,
    CMD_OUT_DEGREE  = 3'd3,
    CMD_CONTAINS    = 3'd4
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture an input word and clear the working flags
    logic scan;        // step the id table scan
    logic vtx_write;   // append the vertex and clear its edge row
    logic edge_write;  // set the edge bit and count the edge
    logic set_status;  // flag an error
    logic set_found;   // flag a positive query answer
    logic pop_load;    // load the edge row into the bit counter
    logic pop_step;    // count one bit of the row
    logic finish;      // present the result word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic scan_done;
    logic hit_a;
    logic hit_b;
    logic full;
    logic bit_hit;
    logic pop_done;
  } dp_status_t;

endpackage

### hdl/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store: controller plus datapath.
// Depends on amgs_pkg, amgs_ctrl, amgs_datapath and amgs_ram.
//
//   Channel   Handshake             Word
//   command   start / busy          command_i, first_id_i, second_id_i
//   result    done_o (one cycle)    status_o, found_o, out_degree_o,
//                                   vertex_total_o, edge_total_o
//
// A command is taken at a clock edge with start high and busy low; the block
// then works on it alone. The id table is scanned once per command, both ids
// of an edge command being matched in the same pass. A command settled by the
// scan alone (a contains query, a rejected vertex, an unknown id or an unused
// code) then finishes; a new vertex first writes its slot, and an edge or
// out-degree command first reads the edge row of its origin. The out-degree
// counts one row bit per cycle up to the highest set bit, at least one bit.
// Each table memory has a single port. The result word appears for one cycle
// on done_o in the cycle in which busy falls, and the receiver cannot stall
// it. Reset clears the counters and the controller at once; no clearing pass
// is needed, because every edge row is zeroed when its slot is taken.
module adjacency_matrix_graph_store #(
  parameter int MAX_VERTICES = 64,
  parameter int ID_BITS      = 32
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start,
  output logic                                           busy,
  input  logic [amgs_pkg::CmdW-1:0]                      command_i,
  input  logic [amgs_pkg::IdPortW-1:0]                   first_id_i,
  input  logic [amgs_pkg::IdPortW-1:0]                   second_id_i,
  output logic                                           done_o,
  output logic                                           status_o,
  output logic                                           found_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]              out_degree_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]              vertex_total_o,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES+1)-1:0] edge_total_o
);
  import amgs_pkg::*;

  // Command and status between the controller and the datapath.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_stat;

  amgs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd)
  );

  amgs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .ID_BITS      (ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .command_i      (command_i),
    .first_id_i     (first_id_i),
    .second_id_i    (second_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .out_degree_o   (out_degree_o),
    .vertex_total_o (vertex_total_o),
    .edge_total_o   (edge_total_o)
  );

endmodule

### hdl/amgs_ram.sv
// Generic single-port RAM with a registered read.
// Stands alone; used by the datapath for the id table and the edge rows.
module amgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/amgs_ctrl.sv
// Controller state machine of the graph store: sequences the scan, the row
// access and the bit count. Depends on amgs_pkg.
module amgs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  amgs_pkg::dp_status_t stat_i,
  output amgs_pkg::ctrl_cmd_t  cmd_o
);
  import amgs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_VWRITE = 7'b0000100,
    S_ROWRD  = 7'b0001000,
    S_ROWUSE = 7'b0010000,
    S_POP    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FIN;
          case (stat_i.cmd)
            CMD_ADD_VERTEX: begin
              // Fullness is tested before the duplicate check.
              if (stat_i.full) begin
                cmd_o.set_status = 1'b1;
              end else if (!stat_i.hit_a) begin
                state_d = S_VWRITE;
              end
            end
            CMD_ADD_EDGE: begin
              if (stat_i.hit_a && stat_i.hit_b) begin
                state_d = S_ROWRD;
              end else begin
                cmd_o.set_status = 1'b1;
              end
            end
            CMD_EDGE_EXISTS: begin
              if (stat_i.hit_a && stat_i.hit_b) begin
                state_d = S_ROWRD;
              end
            end
            CMD_OUT_DEGREE: begin
              if (stat_i.hit_a) begin
                state_d = S_ROWRD;
              end else begin
                cmd_o.set_status = 1'b1;
              end
            end
            CMD_CONTAINS: begin
              cmd_o.set_found = stat_i.hit_a;
            end
            default: begin
              cmd_o.set_status = 1'b1;
            end
          endcase
        end
      end
      S_VWRITE: begin
        cmd_o.vtx_write = 1'b1;
        state_d         = S_FIN;
      end
      S_ROWRD: begin
        // The edge row of the origin slot is being read.
        state_d = S_ROWUSE;
      end
      S_ROWUSE: begin
        state_d = S_FIN;
        case (stat_i.cmd)
          CMD_ADD_EDGE: begin
            if (stat_i.bit_hit) begin
              cmd_o.set_status = 1'b1;
            end else begin
              cmd_o.edge_write = 1'b1;
            end
          end
          CMD_EDGE_EXISTS: begin
            cmd_o.set_found = stat_i.bit_hit;
          end
          CMD_OUT_DEGREE: begin
            cmd_o.pop_load = 1'b1;
            state_d        = S_POP;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        cmd_o.pop_step = 1'b1;
        if (stat_i.pop_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hdl/amgs_datapath.sv
// Datapath of the graph store: id table, edge row memory, counters, scan and
// bit count. Depends on amgs_pkg and amgs_ram.
module amgs_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int ID_BITS      = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  amgs_pkg::ctrl_cmd_t                       cmd_i,
  output amgs_pkg::dp_status_t                      stat_o,
  input  logic [amgs_pkg::CmdW-1:0]                 command_i,
  input  logic [amgs_pkg::IdPortW-1:0]              first_id_i,
  input  logic [amgs_pkg::IdPortW-1:0]              second_id_i,
  output logic                                      done_o,
  output logic                                      status_o,
  output logic                                      found_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]         out_degree_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]         vertex_total_o,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES+1)-1:0] edge_total_o
);
  import amgs_pkg::*;

  localparam int SlotW = $clog2(MAX_VERTICES);
  localparam int CntW  = $clog2(MAX_VERTICES + 1);
  localparam int EdgeW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] RowOne = MAX_VERTICES'(1);

  cmd_e                  cmd_q;
  logic [ID_BITS-1:0]    a_id_q, b_id_q;
  logic [CntW-1:0]       idx_q;
  logic                  rd_pending_q;
  logic [SlotW-1:0]      rd_slot_q;
  logic                  hit_a_q, hit_b_q;
  logic [SlotW-1:0]      slot_a_q, slot_b_q;
  logic [CntW-1:0]       vcount_q;
  logic [EdgeW-1:0]      ecount_q;
  logic [MAX_VERTICES-1:0] row_q;
  logic [SlotW-1:0]      pop_idx_q;
  logic                  status_q, found_q, done_q;
  logic [CntW-1:0]       degree_q;

  logic                  issue;
  logic [SlotW-1:0]      id_addr, row_addr;
  logic [ID_BITS-1:0]    id_rdata;
  logic                  row_we;
  logic [MAX_VERTICES-1:0] row_wdata, row_rdata;

  assign issue    = cmd_i.scan && (idx_q < vcount_q);
  assign id_addr  = cmd_i.vtx_write ? vcount_q[SlotW-1:0] : idx_q[SlotW-1:0];
  assign row_addr = cmd_i.vtx_write ? vcount_q[SlotW-1:0] : slot_a_q;
  assign row_we   = cmd_i.vtx_write | cmd_i.edge_write;
  // A new slot gets a cleared row, so no row is read before it is written.
  assign row_wdata = cmd_i.vtx_write ? '0 : (row_rdata | (RowOne << slot_b_q));

  amgs_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_VERTICES)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.vtx_write),
    .addr_i  (id_addr),
    .wdata_i (a_id_q),
    .rdata_o (id_rdata)
  );

  amgs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      rd_pending_q <= 1'b0;
      vcount_q     <= '0;
      ecount_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      rd_pending_q <= issue;
      done_q       <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.vtx_write) begin
        vcount_q <= vcount_q + CntW'(1);
      end
      if (cmd_i.edge_write) begin
        ecount_q <= ecount_q + EdgeW'(1);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rd_slot_q <= idx_q[SlotW-1:0];
    if (cmd_i.load) begin
      cmd_q    <= cmd_e'(command_i);
      a_id_q   <= ID_BITS'(first_id_i);
      b_id_q   <= ID_BITS'(second_id_i);
      hit_a_q  <= 1'b0;
      hit_b_q  <= 1'b0;
      status_q <= 1'b0;
      found_q  <= 1'b0;
      degree_q <= '0;
    end else begin
      if (rd_pending_q && (id_rdata == a_id_q)) begin
        hit_a_q  <= 1'b1;
        slot_a_q <= rd_slot_q;
      end
      if (rd_pending_q && (id_rdata == b_id_q)) begin
        hit_b_q  <= 1'b1;
        slot_b_q <= rd_slot_q;
      end
      if (cmd_i.set_status) begin
        status_q <= 1'b1;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.pop_step) begin
        degree_q <= degree_q + CntW'(row_q[0]);
      end
    end
    if (cmd_i.pop_load) begin
      row_q     <= row_rdata;
      pop_idx_q <= '0;
    end else if (cmd_i.pop_step) begin
      row_q     <= row_q >> 1;
      pop_idx_q <= pop_idx_q + SlotW'(1);
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.scan_done = (idx_q == vcount_q) && !rd_pending_q;
  assign stat_o.hit_a     = hit_a_q;
  assign stat_o.hit_b     = hit_b_q;
  assign stat_o.full      = (vcount_q == CntW'(MAX_VERTICES));
  assign stat_o.bit_hit   = row_rdata[slot_b_q];
  // The count stops early once no set bit is left above the one being counted.
  assign stat_o.pop_done  = (pop_idx_q == SlotW'(MAX_VERTICES - 1)) ||
                            (row_q[MAX_VERTICES-1:1] == '0);

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign out_degree_o   = degree_q;
  assign vertex_total_o = vcount_q;
  assign edge_total_o   = ecount_q;

endmodule

### hdl/amgs_checker.sv
// Port-level checks for the graph store, attached by a bind statement.
// Depends on amgs_pkg and on the top level adjacency_matrix_graph_store.
module amgs_checker #(
  parameter int MAX_VERTICES = 64
) (
  input logic                                           clk_i,
  input logic                                           rst_ni,
  input logic                                           start,
  input logic                                           busy,
  input logic                                           done_o,
  input logic                                           status_o,
  input logic                                           found_o,
  input logic [$clog2(MAX_VERTICES+1)-1:0]              out_degree_o,
  input logic [$clog2(MAX_VERTICES+1)-1:0]              vertex_total_o
);
  import amgs_pkg::*;

  localparam int CntW = $clog2(MAX_VERTICES + 1);

  // A result word is only shown once the block has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  // A taken command keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command taken but block not busy");

  // A positive query answer never comes with an error.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> !status_o) else $error("found flagged with error");

  // A non-zero degree only comes from a successful out-degree command.
  a_degree_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_degree_o != '0)) |-> (!status_o && !found_o))
    else $error("degree reported with error or found");

  // The vertex total never exceeds the table size.
  a_vtx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (vertex_total_o <= CntW'(MAX_VERTICES)))
    else $error("vertex total beyond table size");

endmodule

bind adjacency_matrix_graph_store amgs_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_amgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .found_o        (found_o),
  .out_degree_o   (out_degree_o),
  .vertex_total_o (vertex_total_o)
);

### tb/graph_store_checker.sv
// Checker for the adjacency matrix graph store: tracks the graph and compares every result word.
// Depends on amgs_pkg for the id width and the command codes.
module graph_store_checker #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [amgs_pkg::CmdW-1:0]    command_i,
  input  logic [amgs_pkg::IdPortW-1:0] first_id_i,
  input  logic [amgs_pkg::IdPortW-1:0] second_id_i,
  input  logic                         done_i,
  input  logic                         status_i,
  input  logic                         found_i,
  input  logic [6:0]                   out_degree_i,
  input  logic [6:0]                   vertex_total_i,
  input  logic [12:0]                  edge_total_i,
  output logic [31:0]                  fail_count_o,
  output logic [31:0]                  pending_o
);

  typedef struct packed {
    logic        status;
    logic        found;
    logic [6:0]  out_degree;
    logic [6:0]  vertex_total;
    logic [12:0] edge_total;
  } graph_answer_t;

  logic [amgs_pkg::IdPortW-1:0] id_table [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]      edge_rows [MAX_VERTICES];
  int                           vertex_count;
  int                           edge_count;
  graph_answer_t                answer_q [$];

  // Slots at and above the vertex count are never looked at.
  function automatic int find_slot(input logic [amgs_pkg::IdPortW-1:0] id);
    int slot;
    slot = -1;
    for (int i = 0; i < vertex_count; i++) begin
      if (slot < 0 && id_table[i] == id) slot = i;
    end
    return slot;
  endfunction

  // Applies one command word to the tracked graph and returns the answer it should give.
  function automatic graph_answer_t apply_command(input logic [amgs_pkg::CmdW-1:0] cmd,
                                                  input logic [amgs_pkg::IdPortW-1:0] a_id,
                                                  input logic [amgs_pkg::IdPortW-1:0] b_id);
    graph_answer_t ans;
    int            a;
    int            b;
    ans = '0;
    a   = find_slot(a_id);
    b   = find_slot(b_id);
    case (cmd)
      amgs_pkg::CMD_ADD_VERTEX: begin
        // Fullness wins over a duplicate id.
        if (vertex_count >= MAX_VERTICES) begin
          ans.status = 1'b1;
        end else if (a < 0) begin
          id_table[vertex_count]  = a_id;
          edge_rows[vertex_count] = '0;
          vertex_count++;
        end
      end
      amgs_pkg::CMD_ADD_EDGE: begin
        if (a < 0 || b < 0) begin
          ans.status = 1'b1;
        end else if (edge_rows[a][b]) begin
          ans.status = 1'b1;
        end else begin
          edge_rows[a][b] = 1'b1;
          edge_count++;
        end
      end
      amgs_pkg::CMD_EDGE_EXISTS: begin
        if (a >= 0 && b >= 0) ans.found = edge_rows[a][b];
      end
      amgs_pkg::CMD_OUT_DEGREE: begin
        if (a < 0) begin
          ans.status = 1'b1;
        end else begin
          for (int c = 0; c < MAX_VERTICES; c++) begin
            ans.out_degree += 7'(edge_rows[a][c]);
          end
        end
      end
      amgs_pkg::CMD_CONTAINS: begin
        ans.found = (a >= 0);
      end
      default: begin
        ans.status = 1'b1;
      end
    endcase
    ans.vertex_total = vertex_count[6:0];
    ans.edge_total   = edge_count[12:0];
    return ans;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    graph_answer_t want;
    int            errs;
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) edge_rows[r] = '0;
      vertex_count = 0;
      edge_count   = 0;
      answer_q.delete();
      fail_count_o <= '0;
      pending_o    <= '0;
    end else begin
      errs = 0;
      // The result is taken before any new word, as both may fall on one edge.
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d found %0d",
                   $time, status_i, found_i);
          errs = 1;
        end else begin
          want = answer_q.pop_front();
          errs += field_differs("status", 32'(want.status), 32'(status_i));
          errs += field_differs("found", 32'(want.found), 32'(found_i));
          errs += field_differs("out_degree", 32'(want.out_degree), 32'(out_degree_i));
          errs += field_differs("vertex_total", 32'(want.vertex_total),
                                32'(vertex_total_i));
          errs += field_differs("edge_total", 32'(want.edge_total), 32'(edge_total_i));
        end
      end
      if (start_i && !busy_i) begin
        answer_q.push_back(apply_command(command_i, first_id_i, second_id_i));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= answer_q.size();
    end
  end

endmodule

### tb/tb_adjacency_matrix_graph_store.sv
// Testbench top for the adjacency matrix graph store: clock, reset, command stimulus and verdict.
// Depends on amgs_pkg, adjacency_matrix_graph_store and graph_store_checker.
module tb_adjacency_matrix_graph_store;

  localparam int MAX_VERTICES = 64;
  localparam int RandomWords  = 1050;
  localparam int CmdW         = amgs_pkg::CmdW;
  // No accepted word for this many cycles means the block has hung.
  localparam int QuietLimit   = 5000;
  // Codes that the package leaves undefined; the block must answer them with an error.
  localparam logic [amgs_pkg::CmdW-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [amgs_pkg::CmdW-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [31:0] ID_ZERO = 32'h0000_0000;
  localparam logic [31:0] ID_ONES = 32'hFFFF_FFFF;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [amgs_pkg::CmdW-1:0]    command_i;
  logic [amgs_pkg::IdPortW-1:0] first_id_i;
  logic [amgs_pkg::IdPortW-1:0] second_id_i;
  logic                         done_o;
  logic                         status_o;
  logic                         found_o;
  logic [6:0]                   out_degree_o;
  logic [6:0]                   vertex_total_o;
  logic [12:0]                  edge_total_o;
  logic [31:0]                  fail_count;
  logic [31:0]                  pending;

  // Ids already offered to the block as new vertices. Only used to steer the
  // random stimulus towards ids that hit; the checker keeps the true graph.
  logic [31:0] offered_ids [$];
  int          burst_left;
  int          quiet_cycles;

  adjacency_matrix_graph_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .ID_BITS     (32)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .first_id_i    (first_id_i),
    .second_id_i   (second_id_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .out_degree_o  (out_degree_o),
    .vertex_total_o(vertex_total_o),
    .edge_total_o  (edge_total_o)
  );

  graph_store_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command_i),
    .first_id_i    (first_id_i),
    .second_id_i   (second_id_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .found_i       (found_o),
    .out_degree_i  (out_degree_o),
    .vertex_total_i(vertex_total_o),
    .edge_total_i  (edge_total_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The sender works in bursts. Within a burst each word follows the last one
  // with no gap; between bursts start drops for a random spell. Gaps are
  // counted from the edge that took the previous word, so a short gap lands
  // while the block is still scanning and a long one after it has gone idle.
  // Now and then a very long burst gives a stretch with no idling at all.
  function automatic int next_gap();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
      gap = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 40);
    end
    return gap;
  endfunction

  // Puts one command word on the ports and returns at the edge that takes it.
  // Start is only lowered when a gap follows, so it never gets two updates in
  // one time step.
  task automatic issue_word(input logic [amgs_pkg::CmdW-1:0] cmd,
                            input logic [31:0] a_id, input logic [31:0] b_id);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i   <= cmd;
    first_id_i  <= a_id;
    second_id_i <= b_id;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Mostly ids that were offered as vertices, so that lookups hit; the rest
  // are the extremes or wholly random; the random ones almost always miss.
  function automatic logic [31:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (offered_ids.size() == 0 || roll < 10) return $urandom;
    if (roll < 15) return ($urandom_range(0, 1) == 1) ? ID_ONES : ID_ZERO;
    return offered_ids[$urandom_range(0, offered_ids.size() - 1)];
  endfunction

  // Edge origins lean on the first few vertices so that their rows fill up
  // and the out-degree count runs over many bits.
  function automatic logic [31:0] pick_origin();
    int hot;
    if (offered_ids.size() > 0 && $urandom_range(0, 9) < 4) begin
      hot = (offered_ids.size() < 4) ? offered_ids.size() - 1 : 3;
      return offered_ids[$urandom_range(0, hot)];
    end
    return pick_id();
  endfunction

  function automatic void note_offered(input logic [31:0] id);
    bit seen;
    seen = 1'b0;
    foreach (offered_ids[i]) if (offered_ids[i] == id) seen = 1'b1;
    if (!seen && offered_ids.size() < MAX_VERTICES) offered_ids.push_back(id);
  endfunction

  task automatic random_word();
    logic [amgs_pkg::CmdW-1:0] cmd;
    logic [31:0]               a_id;
    logic [31:0]               b_id;
    int                        roll;
    roll = $urandom_range(0, 99);
    b_id = $urandom;
    if (roll < 12) begin
      // Mostly fresh ids, so the table fills part way through the run and the
      // rest of it exercises the full table, duplicates included.
      cmd  = amgs_pkg::CMD_ADD_VERTEX;
      a_id = ($urandom_range(0, 3) == 0) ? pick_id() : $urandom;
      note_offered(a_id);
    end else if (roll < 50) begin
      cmd  = amgs_pkg::CMD_ADD_EDGE;
      a_id = pick_origin();
      b_id = pick_id();
    end else if (roll < 66) begin
      cmd  = amgs_pkg::CMD_EDGE_EXISTS;
      a_id = pick_origin();
      b_id = pick_id();
    end else if (roll < 80) begin
      cmd  = amgs_pkg::CMD_OUT_DEGREE;
      a_id = pick_origin();
    end else if (roll < 95) begin
      cmd  = amgs_pkg::CMD_CONTAINS;
      a_id = pick_id();
    end else begin
      cmd  = CmdW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      a_id = pick_id();
    end
    issue_word(cmd, a_id, b_id);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       <= 1'b0;
    command_i   <= amgs_pkg::CMD_ADD_VERTEX;
    first_id_i  <= '0;
    second_id_i <= '0;
    burst_left  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: every query on the empty graph, then the extreme ids,
    // a self loop, a repeated edge, an unknown endpoint and the unused codes.
    issue_word(amgs_pkg::CMD_CONTAINS,    ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_OUT_DEGREE,  ID_ZERO, ID_ONES);
    issue_word(amgs_pkg::CMD_EDGE_EXISTS, ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_VERTEX,  ID_ZERO, ID_ONES);
    issue_word(amgs_pkg::CMD_ADD_VERTEX,  ID_ONES, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_VERTEX,  ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ZERO, ID_ONES);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ONES, ID_ZERO);
    issue_word(amgs_pkg::CMD_ADD_EDGE,    ID_ZERO, 32'h0001_2345);
    issue_word(amgs_pkg::CMD_EDGE_EXISTS, ID_ZERO, ID_ONES);
    issue_word(amgs_pkg::CMD_EDGE_EXISTS, ID_ONES, ID_ONES);
    issue_word(amgs_pkg::CMD_EDGE_EXISTS, ID_ZERO, 32'h0001_2345);
    issue_word(amgs_pkg::CMD_OUT_DEGREE,  ID_ZERO, ID_ZERO);
    issue_word(amgs_pkg::CMD_OUT_DEGREE,  ID_ONES, ID_ZERO);
    issue_word(amgs_pkg::CMD_CONTAINS,    ID_ONES, ID_ZERO);
    issue_word(amgs_pkg::CMD_CONTAINS,    32'h5A5A_5A5A, ID_ONES);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      issue_word(CmdW'(c), ID_ZERO, ID_ONES);
    end
    issue_word(amgs_pkg::CMD_ADD_VERTEX,  32'hAAAA_AAAA, 32'h5555_5555);
    issue_word(amgs_pkg::CMD_ADD_VERTEX,  32'h5555_5555, 32'hAAAA_AAAA);
    offered_ids.push_back(ID_ZERO);
    offered_ids.push_back(ID_ONES);
    offered_ids.push_back(32'hAAAA_AAAA);
    offered_ids.push_back(32'h5555_5555);

    for (int n = 0; n < RandomWords; n++) random_word();

    // Drain: wait for the last result word, sampling away from the active
    // edge, then allow a worst-case command time for anything stray.
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2 * MAX_VERTICES + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a run of cycles in which neither a command nor a result word is
  // taken means the block has stopped answering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no word accepted for %0d cycles", $time, QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### adjacency_matrix_graph_store.f
hdl/amgs_pkg.sv
hdl/amgs_ram.sv
hdl/amgs_ctrl.sv
hdl/amgs_datapath.sv
hdl/adjacency_matrix_graph_store.sv
hdl/amgs_checker.sv
tb/graph_store_checker.sv
tb/tb_adjacency_matrix_graph_store.sv
